// ===== rtl/svm_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, opcodes, fault codes and decode helpers for the stack VM execute unit.
// No dependencies.
package svm_pkg;

    localparam int STACK_DEPTH   = 256;
    localparam int PROGRAM_WORDS = 4096;
    localparam int VAR_WORDS     = 256;

    localparam int WORD_W  = 32;
    localparam int PC_W    = $clog2(PROGRAM_WORDS);
    localparam int CNT_W   = $clog2(STACK_DEPTH) + 1;
    localparam int SP_AW   = $clog2(STACK_DEPTH);
    localparam int VAR_AW  = $clog2(VAR_WORDS);
    localparam int FUNC_W  = 6;
    localparam int FAULT_W = 3;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_ON_FAULT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECKS        = 1'b1;

    localparam logic [FAULT_W-1:0] FLT_NONE  = 3'd0;
    localparam logic [FAULT_W-1:0] FLT_OVER  = 3'd1;
    localparam logic [FAULT_W-1:0] FLT_UNDER = 3'd2;
    localparam logic [FAULT_W-1:0] FLT_DIV0  = 3'd3;
    localparam logic [FAULT_W-1:0] FLT_PC    = 3'd4;
    localparam logic [FAULT_W-1:0] FLT_ASSRT = 3'd5;
    localparam logic [FAULT_W-1:0] FLT_CALL  = 3'd6;

    typedef logic [FUNC_W-1:0] t_func;

    localparam t_func OP_NOP = 6'd0,  OP_PUSH = 6'd1,  OP_POP = 6'd2,   OP_ADD = 6'd3;
    localparam t_func OP_SUB = 6'd4,  OP_MUL = 6'd5,   OP_DIV = 6'd6,   OP_JMP = 6'd7;
    localparam t_func OP_CMP = 6'd8,  OP_JE = 6'd9,    OP_JNE = 6'd10,  OP_JL = 6'd11;
    localparam t_func OP_JG = 6'd12,  OP_JLE = 6'd13,  OP_JGE = 6'd14,  OP_FROM = 6'd15;
    localparam t_func OP_TO = 6'd16,  OP_SFROM = 6'd17, OP_STO = 6'd18, OP_AFROM = 6'd19;
    localparam t_func OP_ATO = 6'd20, OP_CALL = 6'd21, OP_RET = 6'd22,  OP_DUP = 6'd23;
    localparam t_func OP_SWAP = 6'd24, OP_INC = 6'd25, OP_DEC = 6'd26,  OP_STINC = 6'd27;
    localparam t_func OP_STDEC = 6'd28, OP_LAND = 6'd29, OP_LOR = 6'd30, OP_LXOR = 6'd31;
    localparam t_func OP_LNOT = 6'd32, OP_BAND = 6'd33, OP_BOR = 6'd34, OP_BXOR = 6'd35;
    localparam t_func OP_BNOT = 6'd36, OP_ASSERT = 6'd37, OP_QUIT = 6'd38;

    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] dividend;
        logic [WORD_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic [WORD_W-1:0] quotient;
    } t_div_rsp;

    // Words an opcode needs on the data stack.
    function automatic logic [1:0] need_of(input t_func f);
        logic [1:0] n;
        n = 2'd0;
        case (f)
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_CMP, OP_STO, OP_ATO, OP_SWAP,
            OP_LAND, OP_LOR, OP_LXOR, OP_BAND, OP_BOR, OP_BXOR, OP_ASSERT: n = 2'd2;
            OP_POP, OP_TO, OP_SFROM, OP_AFROM, OP_DUP, OP_INC, OP_DEC,
            OP_STDEC, OP_LNOT, OP_BNOT: n = 2'd1;
            default: n = 2'd0;
        endcase
        return n;
    endfunction

    function automatic logic grows(input t_func f);
        return (f == OP_PUSH) || (f == OP_FROM) || (f == OP_DUP) || (f == OP_STINC);
    endfunction

    function automatic logic two_word(input t_func f);
        logic w;
        case (f)
            OP_PUSH, OP_JMP, OP_JE, OP_JNE, OP_JL, OP_JG, OP_JLE, OP_JGE,
            OP_FROM, OP_TO, OP_AFROM, OP_ATO, OP_CALL: w = 1'b1;
            default: w = 1'b0;
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/svm_cmd_if.sv =====
`timescale 1ns / 1ps
// Instruction channel: valid/ready handshake with opcode and argument word.
// Depends on svm_pkg.
interface svm_cmd_if;
    import svm_pkg::*;
    logic              valid;
    logic              ready;
    t_func             func;
    logic [WORD_W-1:0] arg;

    modport source (output valid, output func, output arg, input ready);
    modport sink   (input valid, input func, input arg, output ready);
endinterface

// ===== rtl/svm_res_if.sv =====
`timescale 1ns / 1ps
// Result channel: valid/ready handshake with machine status after one instruction.
// Depends on svm_pkg.
interface svm_res_if;
    import svm_pkg::*;
    logic               valid;
    logic               ready;
    logic [PC_W-1:0]    next_pc;
    logic [WORD_W-1:0]  top_value;
    logic [CNT_W-1:0]   depth;
    logic               flag_eq;
    logic               flag_gr;
    logic [FAULT_W-1:0] fault;
    logic               halted;

    modport source (output valid, output next_pc, output top_value, output depth,
                    output flag_eq, output flag_gr, output fault, output halted,
                    input ready);
    modport sink   (input valid, input next_pc, input top_value, input depth,
                    input flag_eq, input flag_gr, input fault, input halted,
                    output ready);
endinterface

// ===== rtl/svm_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module svm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/svm_div.sv =====
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on svm_pkg.
module svm_div import svm_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    localparam int STEP_W = $clog2(WORD_W) + 1;

    logic                r_busy, n_busy;
    logic [STEP_W-1:0]   r_step, n_step;
    logic [WORD_W-1:0]   r_rem, n_rem;
    logic [WORD_W-1:0]   r_quo, n_quo;
    logic [WORD_W-1:0]   r_den, n_den;
    logic [WORD_W:0]     shifted;
    logic [WORD_W+1:0]   diff;

    always_comb begin
        n_busy  = r_busy;
        n_step  = r_step;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_den   = r_den;
        shifted = {r_rem, r_quo[WORD_W-1]};
        diff    = {1'b0, shifted} - {2'b00, r_den};
        if (i_req.start) begin
            n_busy = 1'b1;
            n_step = STEP_W'(WORD_W);
            n_rem  = '0;
            n_quo  = i_req.dividend;
            n_den  = i_req.divisor;
        end else if (r_busy) begin
            // keep the difference as the partial remainder only when the trial subtract does not borrow
            if (!diff[WORD_W+1]) begin
                n_rem = diff[WORD_W-1:0];
            end else begin
                n_rem = shifted[WORD_W-1:0];
            end
            n_quo  = {r_quo[WORD_W-2:0], ~diff[WORD_W+1]};
            n_step = r_step - STEP_W'(1);
            if (r_step == STEP_W'(1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_step <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.quotient = r_quo;
endmodule

// ===== rtl/stack_vm_execute_unit.sv =====
`timescale 1ns / 1ps
// Stack VM execute unit top level: sequencer, data/return/variable RAMs, divider.
// Items run S_RDT, S_RDS, S_RDV, S_DIV (div only), S_EXEC, S_RDTOP, S_DONE; a new one is taken in S_IDLE.
// The single read port of the data-stack RAM sets this order: top, second and new top are read in turn.
// Synchronous active-low reset clears PC, counts, flags and halt and sets both config bits; RAMs are not cleared.
// Depends on svm_pkg, svm_cmd_if, svm_res_if, svm_ram, svm_div.
module stack_vm_execute_unit import svm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    svm_cmd_if.sink               i_cmd,
    svm_res_if.source             o_res
);
    // Sequencer: read top, read second, read variable, (divide), execute, re-read top, deliver.
    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_RDT   = 8'b00000010,
        S_RDS   = 8'b00000100,
        S_RDV   = 8'b00001000,
        S_DIV   = 8'b00010000,
        S_EXEC  = 8'b00100000,
        S_RDTOP = 8'b01000000,
        S_DONE  = 8'b10000000
    } t_state;

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);

    t_state r_state, n_state;

    // Architectural state
    logic [PC_W-1:0]  r_pc;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] r_rc;
    logic             r_eq, r_gr, r_stopped;
    logic             r_stop_cfg, r_chk_cfg;

    // Per-item working registers
    t_func             r_func;
    logic [WORD_W-1:0] r_arg, r_t, r_s, r_v;
    logic [PC_W-1:0]   r_ret;
    logic              r_swap;

    // Result register
    logic               r_ovalid;
    logic [PC_W-1:0]    r_o_pc;
    logic [WORD_W-1:0]  r_o_top;
    logic [CNT_W-1:0]   r_o_depth;
    logic               r_o_eq, r_o_gr, r_o_halt;
    logic [FAULT_W-1:0] r_o_fault, r_fault;

    // RAM ports
    logic              d_we, v_we, r_we_ret;
    logic [SP_AW-1:0]  d_waddr, d_raddr, rs_waddr, rs_raddr;
    logic [WORD_W-1:0] d_wdata, d_rdata, v_wdata, v_rdata;
    logic [VAR_AW-1:0] v_waddr, v_raddr;
    logic [PC_W-1:0]   rs_wdata, rs_rdata;

    t_div_req div_req;
    t_div_rsp div_rsp;

    logic              accept;
    logic              out_load;
    logic [CNT_W-1:0]  cnt_m1, cnt_m2;
    logic [WORD_W-1:0] t_m, s_m;

    // Execute-stage decode and results
    logic              e_under, e_over, e_ok, e_ceq, e_cgr, e_taken, e_rs_ok, e_halt;
    logic [FAULT_W-1:0] e_fault;
    logic [PC_W:0]     e_seq;
    logic [PC_W-1:0]   e_npc;
    logic              e_npc_hi;
    logic [WORD_W-1:0] e_mul, e_res;
    logic              e_dwe, e_vwe, e_swap;
    logic [CNT_W-1:0]  e_cnt, e_waddr;
    logic [WORD_W-1:0] e_vaddr_full;

    assign accept   = i_cmd.valid && i_cmd.ready;
    assign out_load = (r_state == S_DONE) && (!r_ovalid || o_res.ready);
    assign cnt_m1   = r_cnt - CNT_W'(1);
    assign cnt_m2   = r_cnt - CNT_W'(2);
    assign t_m      = (r_cnt != '0) ? r_t : '0;
    assign s_m      = (r_cnt >= CNT_W'(2)) ? r_s : '0;

    // ---------------------------------------------------------------- memories
    svm_ram #(.WIDTH(WORD_W), .DEPTH(STACK_DEPTH)) u_data_ram (
        .i_clk(i_clk), .i_we(d_we), .i_waddr(d_waddr), .i_wdata(d_wdata),
        .i_raddr(d_raddr), .o_rdata(d_rdata)
    );

    svm_ram #(.WIDTH(PC_W), .DEPTH(STACK_DEPTH)) u_ret_ram (
        .i_clk(i_clk), .i_we(r_we_ret), .i_waddr(rs_waddr), .i_wdata(rs_wdata),
        .i_raddr(rs_raddr), .o_rdata(rs_rdata)
    );

    svm_ram #(.WIDTH(WORD_W), .DEPTH(VAR_WORDS)) u_var_ram (
        .i_clk(i_clk), .i_we(v_we), .i_waddr(v_waddr), .i_wdata(v_wdata),
        .i_raddr(v_raddr), .o_rdata(v_rdata)
    );

    svm_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(div_req), .o_rsp(div_rsp)
    );

    // Second stack word is read only in S_RDT; otherwise point at the current top.
    assign d_raddr  = (r_state == S_RDT) ? cnt_m2[SP_AW-1:0] : cnt_m1[SP_AW-1:0];
    assign rs_raddr = r_rc[SP_AW-1:0] - SP_AW'(1);

    // Variable read address: immediate, top, or top plus offset.
    always_comb begin
        unique case (r_func)
            OP_FROM:  v_raddr = r_arg[VAR_AW-1:0];
            OP_AFROM: v_raddr = VAR_AW'(t_m + r_arg);
            default:  v_raddr = t_m[VAR_AW-1:0];
        endcase
    end

    assign div_req.start    = (r_state == S_RDV) && (r_func == OP_DIV);
    assign div_req.dividend = s_m;
    assign div_req.divisor  = t_m;

    // ---------------------------------------------------------------- execute decode
    always_comb begin
        e_under  = r_cnt < {{(CNT_W-2){1'b0}}, need_of(r_func)};
        e_over   = grows(r_func) && (r_cnt >= CNT_FULL);
        e_ok     = !e_under && !e_over;
        e_ceq    = (s_m == t_m);
        e_cgr    = (s_m > t_m);
        e_rs_ok  = !(((r_func == OP_CALL) && (r_rc >= CNT_FULL)) ||
                     ((r_func == OP_RET) && (r_rc == '0)));

        unique case (r_func)
            OP_JMP, OP_CALL: e_taken = 1'b1;
            OP_JE:  e_taken = r_eq;
            OP_JNE: e_taken = !r_eq;
            OP_JL:  e_taken = !r_eq && !r_gr;
            OP_JG:  e_taken = r_gr;
            OP_JLE: e_taken = !r_gr;
            OP_JGE: e_taken = r_eq || r_gr;
            default: e_taken = 1'b0;
        endcase

        e_seq = {1'b0, r_pc} + (two_word(r_func) ? (PC_W+1)'(2) : (PC_W+1)'(1));
        priority if (e_taken) begin
            e_npc    = r_arg[PC_W-1:0];
            e_npc_hi = |r_arg[WORD_W-1:PC_W];
        end else if ((r_func == OP_RET) && e_rs_ok) begin
            e_npc    = r_ret;
            e_npc_hi = 1'b0;
        end else if (r_func == OP_QUIT) begin
            e_npc    = r_pc;
            e_npc_hi = 1'b0;
        end else begin
            e_npc    = e_seq[PC_W-1:0];
            e_npc_hi = e_seq[PC_W];
        end

        // Fault priority: stack, then divide/assert/call stack, then PC range.
        e_fault = FLT_NONE;
        if (e_under && r_chk_cfg) begin
            e_fault = FLT_UNDER;
        end else if (e_over && r_chk_cfg) begin
            e_fault = FLT_OVER;
        end
        if (e_fault == FLT_NONE && e_ok && r_func == OP_DIV && t_m == '0) begin
            e_fault = FLT_DIV0;
        end
        if (e_fault == FLT_NONE && e_ok && r_func == OP_ASSERT && !e_ceq) begin
            e_fault = FLT_ASSRT;
        end
        if (e_fault == FLT_NONE && !e_rs_ok && r_chk_cfg) begin
            e_fault = FLT_CALL;
        end
        if (e_fault == FLT_NONE && e_npc_hi && r_chk_cfg) begin
            e_fault = FLT_PC;
        end
        e_halt = (e_fault != FLT_NONE) && r_stop_cfg;

        e_mul = s_m * t_m;
        unique case (r_func)
            OP_PUSH:  e_res = r_arg;
            OP_ADD:   e_res = s_m + t_m;
            OP_SUB:   e_res = s_m - t_m;
            OP_MUL:   e_res = e_mul;
            OP_DIV:   e_res = (t_m == '0) ? '1 : div_rsp.quotient;
            OP_FROM, OP_SFROM, OP_AFROM: e_res = r_v;
            OP_DUP:   e_res = t_m;
            OP_SWAP:  e_res = s_m;
            OP_INC:   e_res = t_m + WORD_W'(1);
            OP_DEC:   e_res = t_m - WORD_W'(1);
            OP_LAND:  e_res = WORD_W'((s_m != '0) && (t_m != '0));
            OP_LOR:   e_res = WORD_W'((s_m != '0) || (t_m != '0));
            OP_LXOR:  e_res = WORD_W'(s_m != t_m);
            OP_LNOT:  e_res = WORD_W'(t_m == '0);
            OP_BAND:  e_res = s_m & t_m;
            OP_BOR:   e_res = s_m | t_m;
            OP_BXOR:  e_res = s_m ^ t_m;
            OP_BNOT:  e_res = ~t_m;
            default:  e_res = t_m;
        endcase

        // Stack write and depth change.
        e_dwe   = 1'b0;
        e_swap  = 1'b0;
        e_waddr = r_cnt;
        e_cnt   = r_cnt;
        unique case (r_func)
            OP_PUSH, OP_FROM, OP_DUP: begin
                e_dwe = 1'b1; e_waddr = r_cnt; e_cnt = r_cnt + CNT_W'(1);
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_LAND, OP_LOR, OP_LXOR,
            OP_BAND, OP_BOR, OP_BXOR: begin
                e_dwe = 1'b1; e_waddr = cnt_m2; e_cnt = cnt_m1;
            end
            OP_SFROM, OP_AFROM, OP_INC, OP_DEC, OP_LNOT, OP_BNOT: begin
                e_dwe = 1'b1; e_waddr = cnt_m1;
            end
            OP_SWAP: begin
                e_dwe = 1'b1; e_waddr = cnt_m1; e_swap = 1'b1;
            end
            OP_POP, OP_STDEC: e_cnt = cnt_m1;
            OP_STINC:         e_cnt = r_cnt + CNT_W'(1);
            default: ;
        endcase

        e_vwe = (r_func == OP_TO) || (r_func == OP_STO) || (r_func == OP_ATO);
        unique case (r_func)
            OP_TO:   e_vaddr_full = r_arg;
            OP_STO:  e_vaddr_full = s_m;
            default: e_vaddr_full = t_m + r_arg;
        endcase
    end

    wire exec_go = (r_state == S_EXEC) && !r_stopped && !e_halt;

    // Data RAM: main write in S_EXEC, second half of a swap in S_RDTOP.
    assign d_we    = (exec_go && e_ok && e_dwe) || ((r_state == S_RDTOP) && r_swap);
    assign d_waddr = (r_state == S_RDTOP) ? cnt_m2[SP_AW-1:0] : e_waddr[SP_AW-1:0];
    assign d_wdata = (r_state == S_RDTOP) ? r_t : e_res;

    assign v_we    = exec_go && e_ok && e_vwe;
    assign v_waddr = e_vaddr_full[VAR_AW-1:0];
    assign v_wdata = (r_func == OP_ATO) ? s_m : t_m;

    assign r_we_ret = exec_go && (r_func == OP_CALL) && e_rs_ok;
    assign rs_waddr = r_rc[SP_AW-1:0];
    assign rs_wdata = r_pc + PC_W'(2);

    // ---------------------------------------------------------------- sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (accept) begin n_state = S_RDT; end
            S_RDT:   n_state = S_RDS;
            S_RDS:   n_state = S_RDV;
            S_RDV:   n_state = (r_func == OP_DIV) ? S_DIV : S_EXEC;
            S_DIV:   if (!div_rsp.busy) begin n_state = S_EXEC; end
            S_EXEC:  n_state = S_RDTOP;
            S_RDTOP: n_state = S_DONE;
            S_DONE:  if (out_load) begin n_state = S_IDLE; end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_pc       <= '0;
            r_cnt      <= '0;
            r_rc       <= '0;
            r_eq       <= 1'b0;
            r_gr       <= 1'b0;
            r_stopped  <= 1'b0;
            r_stop_cfg <= 1'b1;
            r_chk_cfg  <= 1'b1;
            r_ovalid   <= 1'b0;
            r_swap     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_STOP_ON_FAULT: r_stop_cfg <= i_cfg_data[0];
                    CFG_CHECKS:        r_chk_cfg  <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (r_state == S_EXEC) begin
                r_swap <= exec_go && e_ok && e_swap;
                if (!r_stopped) begin
                    if (e_halt) begin
                        // hold everything; a failed assert still leaves its compare flags
                        r_stopped <= 1'b1;
                        if (e_fault == FLT_ASSRT) begin
                            r_eq <= e_ceq;
                            r_gr <= e_cgr;
                        end
                    end else begin
                        if (e_ok) begin
                            r_cnt <= e_cnt;
                            if (r_func == OP_CMP || r_func == OP_ASSERT) begin
                                r_eq <= e_ceq;
                                r_gr <= e_cgr;
                            end
                        end
                        if (e_rs_ok && r_func == OP_CALL) begin
                            r_rc <= r_rc + CNT_W'(1);
                        end
                        if (e_rs_ok && r_func == OP_RET) begin
                            r_rc <= r_rc - CNT_W'(1);
                        end
                        if (r_func == OP_QUIT) begin
                            r_stopped <= 1'b1;
                        end
                        r_pc <= e_npc;
                    end
                end
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Payload registers: item fields, fetched operands, result fields.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func <= (i_cmd.func > OP_QUIT) ? OP_NOP : i_cmd.func;
            r_arg  <= i_cmd.arg;
        end
        if (r_state == S_RDT) begin
            r_t   <= d_rdata;
            r_ret <= rs_rdata;
        end
        if (r_state == S_RDS) begin
            r_s <= d_rdata;
        end
        if (r_state == S_RDV) begin
            r_v <= v_rdata;
        end
        if (r_state == S_EXEC) begin
            r_fault <= r_stopped ? FLT_NONE : e_fault;
        end
        if (out_load) begin
            r_o_pc    <= r_pc;
            r_o_top   <= (r_cnt != '0) ? d_rdata : '0;
            r_o_depth <= r_cnt;
            r_o_eq    <= r_eq;
            r_o_gr    <= r_gr;
            r_o_fault <= r_fault;
            r_o_halt  <= r_stopped;
        end
    end

    assign i_cmd.ready     = (r_state == S_IDLE);
    assign o_res.valid     = r_ovalid;
    assign o_res.next_pc   = r_o_pc;
    assign o_res.top_value = r_o_top;
    assign o_res.depth     = r_o_depth;
    assign o_res.flag_eq   = r_o_eq;
    assign o_res.flag_gr   = r_o_gr;
    assign o_res.fault     = r_o_fault;
    assign o_res.halted    = r_o_halt;

    // ---------------------------------------------------------------- checks
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt <= CNT_FULL) && (r_rc <= CNT_FULL))
        else $error("stack count beyond depth");

    a_halt_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) && r_stopped |=> $stable(r_cnt) && $stable(r_pc) && $stable(r_rc))
        else $error("halted machine changed state");

    a_div_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.busy |-> (r_state == S_DIV))
        else $error("divider busy outside divide state");
endmodule
